@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/lruttl_pkg.sv @@
package lruttl_pkg;

  localparam int unsigned DEPTH_DEF       = 16;
  localparam int unsigned KEY_WIDTH_DEF   = 32;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  localparam int unsigned FIELD_W = 32;  // key, value and data port width
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned LIMIT_W = 5;
  localparam int unsigned COUNT_W = 5;   // entry_count port width
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    CMD_GET   = 2'd0,
    CMD_PUT   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TTL   = 2'd1;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = 5'd16;
  localparam logic [TIME_W-1:0]  TTL_RST   = 32'd1000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DEC,
    S_UPD,
    S_RESP
  } state_t;

endpackage

@@ hw/rtl/lruttl_mem.sv @@
module lruttl_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned DW    = 100
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/lru_cache_with_ttl_core.sv @@
// Fully associative key/value cache, LRU replacement, TTL expiry.
// One item in, one result out. Entries (key, value, stamp, recency rank)
// live in a single-port-read, single-port-write RAM with a registered
// read; valid bits, entry count and time sit in flops. Every get and put
// walks the whole RAM one entry per cycle in a scan pass, so the time it
// takes grows with DEPTH; a put then makes a read-modify-write pass that
// renumbers ranks. A new item is taken once the previous one has finished
// its work, even if its result has not yet been taken: the result
// register then holds until out_ready. Config writes are always accepted;
// entry_limit 0 behaves as 1, above DEPTH as DEPTH.
module lru_cache_with_ttl_core
  import lruttl_pkg::*;
#(
  parameter int unsigned DEPTH       = DEPTH_DEF,
  parameter int unsigned KEY_WIDTH   = KEY_WIDTH_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // command transfer
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_cmd,
  input  logic [FIELD_W-1:0]   in_lookup_key,
  input  logic [FIELD_W-1:0]   in_put_value,
  // result transfer
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_hit,
  output logic [FIELD_W-1:0]   out_read_value,
  output logic                 out_evicted,
  output logic [COUNT_W-1:0]   out_entry_count,
  // config transfer
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FIELD_W-1:0]   cfg_data
);

  `include "assert_macros.svh"

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = AW + 1;
  // RAM word: {key, value, stamp, rank}
  localparam int unsigned DW = KEY_WIDTH + VALUE_WIDTH + TIME_W + AW;
  localparam int unsigned RK_LO = 0;
  localparam int unsigned ST_LO = AW;
  localparam int unsigned VL_LO = AW + TIME_W;
  localparam int unsigned KY_LO = AW + TIME_W + VALUE_WIDTH;

  state_t state_r, state_nxt;

  // config
  logic [LIMIT_W-1:0] limit_r;
  logic [TIME_W-1:0]  ttl_r;
  logic [CW-1:0]      eff_lim;

  // cache state in flops
  logic [DEPTH-1:0]   valid_r;
  logic [CW-1:0]      count_r;
  logic [TIME_W-1:0]  time_r;

  // current item
  cmd_t                   cmd_r;
  logic [KEY_WIDTH-1:0]   key_r;
  logic [VALUE_WIDTH-1:0] val_r;

  // pass sequencing
  logic [PW-1:0] ph_r;
  logic [AW-1:0] sidx;
  logic          proc;

  // scan findings
  logic                   found_r;
  logic [AW-1:0]          match_idx_r;
  logic [AW-1:0]          match_rank_r;
  logic [VALUE_WIDTH-1:0] match_val_r;
  logic [TIME_W-1:0]      match_stamp_r;
  logic                   vic_found_r;
  logic [AW-1:0]          vic_idx_r;
  logic [AW-1:0]          vic_rank_r;
  logic                   free_found_r;
  logic [AW-1:0]          free_idx_r;

  // decision
  logic          evict;
  logic [AW-1:0] ins_slot;
  logic          ins_ok;
  logic [TIME_W-1:0] age;
  logic [AW-1:0] slot_r;
  logic          upd_hit_r;
  logic          upd_ins_r;

  // result
  logic                   res_hit_r;
  logic [FIELD_W-1:0]     res_val_r;
  logic                   res_evict_r;
  logic                   out_valid_r;
  logic                   out_hit_r;
  logic [FIELD_W-1:0]     out_val_r;
  logic                   out_evict_r;
  logic [COUNT_W-1:0]     out_cnt_r;

  // RAM port
  logic                   mem_we;
  logic [DW-1:0]          mem_wdata;
  logic [DW-1:0]          mem_rdata;
  logic [KEY_WIDTH-1:0]   rd_key;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic [TIME_W-1:0]      rd_stamp;
  logic [AW-1:0]          rd_rank;

  logic in_fire;
  logic load_out;

  lruttl_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (DW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (sidx),
    .wdata (mem_wdata),
    .raddr (ph_r[AW-1:0]),
    .rdata (mem_rdata)
  );

  assign rd_key   = mem_rdata[KY_LO +: KEY_WIDTH];
  assign rd_val   = mem_rdata[VL_LO +: VALUE_WIDTH];
  assign rd_stamp = mem_rdata[ST_LO +: TIME_W];
  assign rd_rank  = mem_rdata[RK_LO +: AW];

  // entry whose read data is on the RAM output this cycle
  assign sidx = AW'(ph_r - PW'(1));
  assign proc = (ph_r != '0);

  always_comb begin
    if (limit_r == '0) begin
      eff_lim = CW'(1);
    end else if (32'(limit_r) > 32'(DEPTH)) begin
      eff_lim = CW'(DEPTH);
    end else begin
      eff_lim = CW'(limit_r);
    end
  end

  assign evict = !found_r && (count_r >= eff_lim) && (count_r != '0) && vic_found_r;
  assign ins_ok = evict || free_found_r;
  // first free slot once the victim has gone
  assign ins_slot = (evict && !(free_found_r && free_idx_r < vic_idx_r)) ? vic_idx_r
                                                                         : free_idx_r;
  assign age = time_r - match_stamp_r;

  // ---------------- FSM: next state ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (cmd_t'(in_cmd) == CMD_GET || cmd_t'(in_cmd) == CMD_PUT) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_SCAN: begin
        if (ph_r == PW'(DEPTH)) state_nxt = S_DEC;
      end
      S_DEC: begin
        state_nxt = (cmd_r == CMD_PUT) ? S_UPD : S_RESP;
      end
      S_UPD: begin
        if (ph_r == PW'(DEPTH)) state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------- FSM: outputs ----------------
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_RESP: load_out = !out_valid_r || out_ready;
      default: begin
        in_ready = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  assign in_fire = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // write-back during the update pass
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = mem_rdata;
    if (state_r == S_UPD && proc) begin
      if (sidx == slot_r && (upd_hit_r || upd_ins_r)) begin
        mem_we    = 1'b1;
        mem_wdata = {key_r, val_r, time_r, AW'(0)};
      end else if (valid_r[sidx] &&
                   (upd_ins_r || (upd_hit_r && rd_rank < match_rank_r))) begin
        mem_we    = 1'b1;
        mem_wdata = {rd_key, rd_val, rd_stamp, AW'(rd_rank + AW'(1))};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RST;
      ttl_r   <= TTL_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_LIMIT) limit_r <= LIMIT_W'(cfg_data);
      if (cfg_index == CFG_TTL)   ttl_r   <= TIME_W'(cfg_data);
    end
  end

  // control state: valid bits, count, time, pass counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      time_r  <= '0;
      ph_r    <= '0;
    end else begin
      if (state_r == S_SCAN || state_r == S_UPD) begin
        ph_r <= (ph_r == PW'(DEPTH)) ? '0 : PW'(ph_r + PW'(1));
      end else begin
        ph_r <= '0;
      end
      if (in_fire && cmd_t'(in_cmd) == CMD_CLEAR) begin
        valid_r <= '0;
        count_r <= '0;
      end
      if (in_fire && cmd_t'(in_cmd) == CMD_TICK) begin
        time_r <= time_r + TIME_W'(1);
      end
      if (state_r == S_DEC && cmd_r == CMD_PUT && !found_r) begin
        if (evict) valid_r[vic_idx_r] <= 1'b0;
        if (ins_ok) valid_r[ins_slot] <= 1'b1;
        count_r <= CW'(count_r - CW'(evict) + CW'(ins_ok));
      end
    end
  end

  // item capture, scan bookkeeping, decision (payload, no reset)
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r        <= cmd_t'(in_cmd);
      key_r        <= KEY_WIDTH'(in_lookup_key);
      val_r        <= VALUE_WIDTH'(in_put_value);
      found_r      <= 1'b0;
      vic_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      res_hit_r    <= 1'b0;
      res_val_r    <= '0;
      res_evict_r  <= 1'b0;
      upd_hit_r    <= 1'b0;
      upd_ins_r    <= 1'b0;
    end
    if (state_r == S_SCAN && proc) begin
      if (valid_r[sidx]) begin
        if (!found_r && rd_key == key_r) begin
          found_r       <= 1'b1;
          match_idx_r   <= sidx;
          match_rank_r  <= rd_rank;
          match_val_r   <= rd_val;
          match_stamp_r <= rd_stamp;
        end
        if (!vic_found_r || rd_rank > vic_rank_r) begin
          vic_found_r <= 1'b1;
          vic_idx_r   <= sidx;
          vic_rank_r  <= rd_rank;
        end
      end else if (!free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= sidx;
      end
    end
    if (state_r == S_DEC) begin
      if (cmd_r == CMD_GET) begin
        res_hit_r <= found_r && (age <= ttl_r);
        res_val_r <= (found_r && (age <= ttl_r)) ? FIELD_W'(match_val_r) : '0;
      end else begin
        res_evict_r <= evict;
        upd_hit_r   <= found_r;
        upd_ins_r   <= !found_r && ins_ok;
        slot_r      <= found_r ? match_idx_r : ins_slot;
      end
    end
  end

  // result register: holds until taken, lets the next item start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_hit_r   <= res_hit_r;
      out_val_r   <= res_val_r;
      out_evict_r <= res_evict_r;
      out_cnt_r   <= COUNT_W'(count_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_read_value  = out_val_r;
  assign out_evicted     = out_evict_r;
  assign out_entry_count = out_cnt_r;

  // ---------------- checks ----------------
  `ASSERT_CLK(a_count_matches_valid, $countones(valid_r) == 32'(count_r), "count and valid bits disagree")
  `ASSERT_CLK(a_count_bound, count_r <= CW'(DEPTH), "entry count above depth")
  `ASSERT_CLK(a_busy_after_accept, in_fire |=> !in_ready, "new item taken while busy")
  `ASSERT_CLK(a_evict_not_hit, (out_valid && out_evicted) |-> !out_hit, "eviction flagged on a hit")

endmodule

@@ bench/lru_cache_with_ttl_core_tb.sv @@
module lru_cache_with_ttl_core_tb;
  import lruttl_pkg::*;

  localparam int NSLOT = 16;
  localparam int STALL_LIMIT = 20000;  // cycles with no transfer at all

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_cmd = CMD_GET;
  logic [FIELD_W-1:0] in_lookup_key = '0;
  logic [FIELD_W-1:0] in_put_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_hit;
  logic [FIELD_W-1:0] out_read_value;
  logic out_evicted;
  logic [COUNT_W-1:0] out_entry_count;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_LIMIT;
  logic [FIELD_W-1:0] cfg_data = '0;

  lru_cache_with_ttl_core DUT (.*);

  typedef struct packed {
    cmd_t cmd;
    logic [31:0] key;
    logic [31:0] val;
  } cache_cmd_t;

  typedef struct packed {
    logic hit;
    logic [31:0] rdata;
    logic evicted;
    logic [4:0] count;
  } cache_resp_t;

  cache_cmd_t cmd_q[$];
  cache_resp_t resp_q[$];

  // Shadow copy of the cache
  logic [4:0] lim_reg;
  logic [31:0] ttl_reg;
  logic sh_valid[NSLOT];
  logic [31:0] sh_key[NSLOT];
  logic [31:0] sh_val[NSLOT];
  logic [31:0] sh_stamp[NSLOT];
  logic [4:0] sh_rank[NSLOT];
  logic [4:0] sh_count;
  logic [31:0] sh_time;

  int errors = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;  // long receiver hold-off requested by stimulus
  bit in_acc = 1'b0;    // input transfer at the last rising edge

  always #4 clk = ~clk;

  function automatic int find_slot(logic [31:0] k);
    for (int i = 0; i < NSLOT; i++)
      if (sh_valid[i] && sh_key[i] == k) return i;
    return -1;
  endfunction

  // Apply one command to the shadow and return the expected response
  function automatic cache_resp_t cache_apply(cache_cmd_t c);
    cache_resp_t r;
    int s, victim;
    logic [4:0] lim, best;
    logic [31:0] age;
    r = '0;
    case (c.cmd)
      CMD_GET: begin
        s = find_slot(c.key);
        if (s >= 0) begin
          age = sh_time - sh_stamp[s];
          if (age <= ttl_reg) begin
            r.hit = 1'b1;
            r.rdata = sh_val[s];
          end
        end
      end
      CMD_PUT: begin
        s = find_slot(c.key);
        if (s >= 0) begin
          for (int i = 0; i < NSLOT; i++)
            if (sh_valid[i] && sh_rank[i] < sh_rank[s]) sh_rank[i]++;
          sh_rank[s] = 0;
          sh_val[s] = c.val;
          sh_stamp[s] = sh_time;
        end else begin
          lim = (lim_reg == 0) ? 5'd1 : (lim_reg > NSLOT ? 5'(NSLOT) : lim_reg);
          if (sh_count >= lim && sh_count > 0) begin
            victim = -1;
            best = 0;
            for (int i = 0; i < NSLOT; i++)
              if (sh_valid[i] && (victim < 0 || sh_rank[i] > best)) begin
                victim = i;
                best = sh_rank[i];
              end
            if (victim >= 0) begin
              sh_valid[victim] = 1'b0;
              sh_count--;
              r.evicted = 1'b1;
            end
          end
          s = -1;
          for (int i = NSLOT - 1; i >= 0; i--)
            if (!sh_valid[i]) s = i;
          if (s >= 0) begin
            for (int i = 0; i < NSLOT; i++)
              if (sh_valid[i]) sh_rank[i]++;
            sh_valid[s] = 1'b1;
            sh_key[s] = c.key;
            sh_val[s] = c.val;
            sh_stamp[s] = sh_time;
            sh_rank[s] = 0;
            sh_count++;
          end
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < NSLOT; i++) sh_valid[i] = 1'b0;
        sh_count = 0;
      end
      default: sh_time = sh_time + 1;
    endcase
    r.count = sh_count;
    return r;
  endfunction

  always @(posedge clk) begin
    in_acc <= in_valid && in_ready;
  end

  // Driver: bursts of transfers with random gaps
  int gap_left = 0;
  int burst_left = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_acc) begin
        if (cmd_q.size() > 0 && gap_left == 0) begin
          in_valid <= 1'b1;
          in_cmd <= cmd_q[0].cmd;
          in_lookup_key <= cmd_q[0].key;
          in_put_value <= cmd_q[0].val;
          resp_q.push_back(cache_apply(cmd_q.pop_front()));
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
          end
          burst_left--;
          if (burst_left == 0) gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end else begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end
      end
    end
  end

  // Receiver stall pattern, with a long hold-off on request
  int rx_phase = 0;
  always @(negedge clk) begin
    rx_phase <= rx_phase + 1;
    if (hold_off) out_ready <= 1'b0;
    else if ((rx_phase / 200) % 3 == 0) out_ready <= 1'b1;  // stretch without stalls
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  // Monitor
  cache_resp_t got, want;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (out_valid && out_ready) begin
        got = '{out_hit, out_read_value, out_evicted, out_entry_count};
        if (resp_q.size() == 0) begin
          $display("%0t: result with none expected: %p", $time, got);
          errors++;
        end else begin
          want = resp_q.pop_front();
          if (got.hit !== want.hit) begin
            $display("%0t: hit expected %0b actual %0b", $time, want.hit, got.hit);
            errors++;
          end
          if (got.rdata !== want.rdata) begin
            $display("%0t: read_value expected %h actual %h", $time, want.rdata, got.rdata);
            errors++;
          end
          if (got.evicted !== want.evicted) begin
            $display("%0t: evicted expected %0b actual %0b", $time, want.evicted,
                     got.evicted);
            errors++;
          end
          if (got.count !== want.count) begin
            $display("%0t: entry_count expected %0d actual %0d", $time, want.count,
                     got.count);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic wait_drained();
    while (cmd_q.size() > 0 || resp_q.size() > 0 || in_valid) @(posedge clk);
    repeat (50) @(posedge clk);  // quiet spell before the next register write
  endtask

  task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_LIMIT) lim_reg = d[4:0];
    else if (idx == CFG_TTL) ttl_reg = d;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void push_cmd(cmd_t c, logic [31:0] k, logic [31:0] v);
    cmd_q.push_back('{c, k, v});
  endfunction

  // Random phase: small key pool to get hits, a few full-range keys
  task automatic random_phase(int n, int tick_wt);
    logic [31:0] pool[8];
    int p;
    foreach (pool[i]) pool[i] = $urandom;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, 99);
      if (p < 40)
        push_cmd(CMD_GET, ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, 7)],
                 $urandom);
      else if (p < 40 + 45 - tick_wt)
        push_cmd(CMD_PUT, ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, 7)],
                 $urandom);
      else if (p < 87)
        push_cmd(CMD_TICK, $urandom, $urandom);
      else if (p < 89)
        push_cmd(CMD_CLEAR, $urandom, $urandom);
      else
        push_cmd(CMD_PUT, $urandom, $urandom);
    end
  endtask

  initial begin
    lim_reg = LIMIT_RST;
    ttl_reg = TTL_RST;
    for (int i = 0; i < NSLOT; i++) begin
      sh_valid[i] = 1'b0;
      sh_key[i] = '0;
      sh_val[i] = '0;
      sh_stamp[i] = '0;
      sh_rank[i] = '0;
    end
    sh_count = 0;
    sh_time = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, every command, expiry at the TTL edge
    reg_write(CFG_TTL, 32'd2);
    push_cmd(CMD_GET, 32'h0, 32'h0);
    push_cmd(CMD_PUT, 32'h0, 32'hFFFF_FFFF);
    push_cmd(CMD_PUT, 32'hFFFF_FFFF, 32'h0);
    push_cmd(CMD_GET, 32'h0, 32'h0);
    push_cmd(CMD_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_cmd(CMD_TICK, 32'h0, 32'h0);
    push_cmd(CMD_TICK, 32'h0, 32'h0);
    push_cmd(CMD_GET, 32'h0, 32'h0);       // age equals ttl: hit
    push_cmd(CMD_TICK, 32'h0, 32'h0);
    push_cmd(CMD_GET, 32'h0, 32'h0);       // expired, still counted
    push_cmd(CMD_PUT, 32'h0, 32'h5A5A_A5A5); // refresh existing key
    push_cmd(CMD_GET, 32'h0, 32'h0);
    push_cmd(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_cmd(CMD_GET, 32'h0, 32'h0);
    wait_drained();

    // Limit of zero behaves as one
    reg_write(CFG_LIMIT, 5'd0);
    for (int i = 0; i < 4; i++) push_cmd(CMD_PUT, 32'h100 + i, i);
    push_cmd(CMD_GET, 32'h103, 32'h0);
    wait_drained();

    // Limit above depth, then lowered below the count
    reg_write(CFG_LIMIT, 5'd31);
    for (int i = 0; i < 18; i++) push_cmd(CMD_PUT, 32'h200 + i, i);
    wait_drained();
    reg_write(CFG_LIMIT, 5'd3);
    push_cmd(CMD_PUT, 32'h300, 32'h1);
    push_cmd(CMD_PUT, 32'h301, 32'h2);
    wait_drained();

    // TTL extremes
    reg_write(CFG_TTL, 32'hFFFF_FFFF);
    reg_write(CFG_LIMIT, 5'd16);
    random_phase(300, 5);
    wait_drained();
    reg_write(CFG_TTL, 32'd0);
    reg_write(CFG_LIMIT, 5'd1);
    random_phase(250, 20);
    wait_drained();

    // Receiver holds off while the sender keeps offering
    reg_write(CFG_TTL, 32'd40);
    reg_write(CFG_LIMIT, 5'd6);
    random_phase(40, 10);
    hold_off = 1'b1;
    repeat (600) @(posedge clk);
    hold_off = 1'b0;
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      reg_write(CFG_LIMIT, $urandom_range(2, 16));
      reg_write(CFG_TTL, $urandom_range(3, 60));
      random_phase(300, 10);
      wait_drained();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/lruttl_pkg.sv
hw/rtl/lruttl_mem.sv
hw/rtl/lru_cache_with_ttl_core.sv
bench/lru_cache_with_ttl_core_tb.sv
